>>> hdl/sqbg_pkg.sv
package sqbg_pkg;

    localparam int MAX_SLOTS    = 32;
    localparam int MAX_INDICES  = 6144;
    localparam int QUAD_INDICES = 6;
    localparam int SLOT_W       = 5;
    localparam int CNT_W        = 6;
    localparam int IDX_W        = 13;
    localparam int XY_W         = 24;
    localparam int Z_W          = 16;
    localparam int COLOR_W      = 32;
    localparam int SIZE_W       = 24;
    localparam int ANGLE_W      = 16;
    localparam int TEX_W        = 32;
    localparam int TRIG_W       = 16;
    localparam int MA_W         = 25;
    localparam int MB_W         = 17;
    localparam int MP_W         = 42;
    localparam int SUM_W        = 44;
    localparam int POS_W        = 28;

    localparam logic signed [POS_W-1:0] XY_MAX = POS_W'(8388607);
    localparam logic signed [POS_W-1:0] XY_MIN = -POS_W'(8388608);

    typedef enum logic [2:0] {
        S_IDLE,
        S_END,
        S_SEARCH,
        S_SIN,
        S_COS,
        S_MUL,
        S_OUT
    } t_state;

    // operands of one sine evaluation
    typedef struct packed {
        logic        sat;
        logic        neg;
        logic [14:0] base;
        logic [10:0] diff;
        logic [9:0]  frac;
    } t_trig_op;

    function automatic logic [14:0] quarter_sine(input logic [4:0] idx);
        logic [14:0] v;
        unique case (idx)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd1606;
            5'd2:    v = 15'd3196;
            5'd3:    v = 15'd4756;
            5'd4:    v = 15'd6270;
            5'd5:    v = 15'd7723;
            5'd6:    v = 15'd9102;
            5'd7:    v = 15'd10394;
            5'd8:    v = 15'd11585;
            5'd9:    v = 15'd12665;
            5'd10:   v = 15'd13623;
            5'd11:   v = 15'd14449;
            5'd12:   v = 15'd15137;
            5'd13:   v = 15'd15679;
            5'd14:   v = 15'd16069;
            5'd15:   v = 15'd16305;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

    function automatic t_trig_op trig_op(input logic [ANGLE_W-1:0] a);
        t_trig_op    op;
        logic [14:0] x;
        logic [4:0]  idx;
        logic [14:0] nxt;
        x        = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        idx      = x[14:10];
        op.sat   = idx[4];
        op.neg   = a[15];
        op.base  = quarter_sine(idx);
        nxt      = quarter_sine(idx + 5'd1);
        op.diff  = op.sat ? 11'd0 : 11'(nxt - op.base);
        op.frac  = x[9:0];
        return op;
    endfunction

    function automatic logic signed [TRIG_W-1:0] trig_val(input t_trig_op op,
                                                          input logic [MP_W-1:0] prod);
        logic [14:0] mag;
        mag = op.sat ? 15'd16384 : (op.base + {4'd0, prod[20:10]});
        return op.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

>>> hdl/sqbg_if.sv
interface sqbg_in_if;
    import sqbg_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [XY_W-1:0]    center_x;
    logic signed [XY_W-1:0]    center_y;
    logic signed [Z_W-1:0]     depth_z;
    logic [COLOR_W-1:0]        fill_color;
    logic [SIZE_W-1:0]         quad_width;
    logic [SIZE_W-1:0]         quad_height;
    logic [ANGLE_W-1:0]        angle;
    logic [TEX_W-1:0]          texture_id;
    modport source (output valid, kind, center_x, center_y, depth_z, fill_color,
                    quad_width, quad_height, angle, texture_id, input ready);
    modport sink   (input valid, kind, center_x, center_y, depth_z, fill_color,
                    quad_width, quad_height, angle, texture_id, output ready);
endinterface

interface sqbg_out_if;
    import sqbg_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [XY_W-1:0]    vertex_x;
    logic signed [XY_W-1:0]    vertex_y;
    logic signed [Z_W-1:0]     vertex_z;
    logic [COLOR_W-1:0]        vertex_color;
    logic                      tex_u;
    logic                      tex_v;
    logic [SLOT_W-1:0]         slot_index;
    logic                      flush_before;
    logic [IDX_W-1:0]          flushed_indices;
    logic                      last;
    modport source (output valid, vertex_x, vertex_y, vertex_z, vertex_color, tex_u, tex_v,
                    slot_index, flush_before, flushed_indices, last, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, vertex_color, tex_u, tex_v,
                    slot_index, flush_before, flushed_indices, last, output ready);
endinterface

>>> hdl/sqbg_mul.sv
module sqbg_mul
    import sqbg_pkg::*;
(
    input  logic                   i_clk,
    input  logic signed [MA_W-1:0] i_a,
    input  logic signed [MB_W-1:0] i_b,
    output logic signed [MP_W-1:0] o_p
);

    logic signed [MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

>>> hdl/sqbg_corner.sv
module sqbg_corner
    import sqbg_pkg::*;
(
    input  logic signed [MP_W-1:0] i_p [4],
    input  logic [1:0]             i_corner,
    input  logic signed [XY_W-1:0] i_cx,
    input  logic signed [XY_W-1:0] i_cy,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y
);

    // products: 0 = w*s, 1 = h*s, 2 = w*c, 3 = h*c
    logic                    sx_neg;
    logic                    sy_neg;
    logic signed [SUM_W-1:0] ws, hs, wc, hc;
    logic signed [SUM_W-1:0] tx, ty, rx, ry;
    logic signed [POS_W-1:0] px, py;

    function automatic logic signed [XY_W-1:0] clip(input logic signed [POS_W-1:0] v);
        logic signed [POS_W-1:0] c;
        if (v > XY_MAX) begin
            c = XY_MAX;
        end else if (v < XY_MIN) begin
            c = XY_MIN;
        end else begin
            c = v;
        end
        return c[XY_W-1:0];
    endfunction

    always_comb begin
        sx_neg = (i_corner == 2'd0) || (i_corner == 2'd3);
        sy_neg = !i_corner[1];
        ws = SUM_W'(i_p[0]);
        hs = SUM_W'(i_p[1]);
        wc = SUM_W'(i_p[2]);
        hc = SUM_W'(i_p[3]);
        tx = (sx_neg ? -wc : wc) - (sy_neg ? -hs : hs);
        ty = (sx_neg ? -ws : ws) + (sy_neg ? -hc : hc);
        // round half up, drop q14 scale and halve
        rx = (tx + SUM_W'(16384)) >>> 15;
        ry = (ty + SUM_W'(16384)) >>> 15;
        px = POS_W'(i_cx) + rx[POS_W-1:0];
        py = POS_W'(i_cy) + ry[POS_W-1:0];
        o_x = clip(px);
        o_y = clip(py);
    end

endmodule

>>> hdl/sprite_quad_batch_generator_unit.sv
// sprite quad batch generator: takes one item at a time, either a sprite quad or an
// end-of-batch command. a quad first closes the open batch when its index count or its
// texture slots are full, then looks its texture up in the slot table one entry per
// cycle (claiming the next slot on a miss), evaluates sine and cosine of the angle
// and the four width/height products on one shared registered multiplier, and emits
// four corner items through an output register. the slot search visits at most the
// slots in use plus one. no clearing pass is needed after reset.
module sprite_quad_batch_generator_unit
    import sqbg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    sqbg_in_if.sink    i_in,
    sqbg_out_if.source o_out
);

    // control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_slots_used, n_slots_used;
    logic [IDX_W-1:0]  r_index_total, n_index_total;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [2:0]        r_step, n_step;
    logic [1:0]        r_corner, n_corner;
    logic              r_ovalid, n_ovalid;

    // quad payload
    logic signed [XY_W-1:0]   r_cx, r_cy;
    logic signed [Z_W-1:0]    r_z;
    logic [COLOR_W-1:0]       r_color;
    logic [SIZE_W-1:0]        r_w, r_h;
    logic [ANGLE_W-1:0]       r_angle;
    logic [TEX_W-1:0]         r_tex;
    logic                     r_flush;
    logic [IDX_W-1:0]         r_fcnt;
    logic [SLOT_W-1:0]        r_slot;
    logic signed [TRIG_W-1:0] r_sin, r_cos;
    logic signed [MP_W-1:0]   r_p [4];
    logic [TEX_W-1:0]         r_table [1:MAX_SLOTS-1];

    // output register
    logic signed [XY_W-1:0]   r_ox, r_oy;
    logic signed [Z_W-1:0]    r_oz;
    logic [COLOR_W-1:0]       r_ocolor;
    logic                     r_ou, r_ov;
    logic [SLOT_W-1:0]        r_oslot;
    logic                     r_oflush;
    logic [IDX_W-1:0]         r_ofcnt;
    logic                     r_olast;

    logic                     accept, out_free, load_end, load_corner;
    logic                     search_hit, search_miss;
    logic [TEX_W-1:0]         table_rd;
    t_trig_op                 op_s, op_c;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MP_W-1:0]   mul_p;
    logic signed [XY_W-1:0]   cx_out, cy_out;

    sqbg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    sqbg_corner u_corner (
        .i_p      (r_p),
        .i_corner (r_corner),
        .i_cx     (r_cx),
        .i_cy     (r_cy),
        .o_x      (cx_out),
        .o_y      (cy_out)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign out_free    = !r_ovalid || o_out.ready;
    assign load_end    = (r_state == S_END) && out_free;
    assign load_corner = (r_state == S_OUT) && out_free;

    // slot 0 is reserved and always reads as untextured
    assign table_rd    = (r_idx[SLOT_W-1:0] == '0) ? '0 : r_table[r_idx[SLOT_W-1:0]];
    assign search_miss = (r_state == S_SEARCH) && (r_idx >= r_slots_used);
    assign search_hit  = (r_state == S_SEARCH) && !search_miss && (table_rd == r_tex);

    assign op_s = trig_op(r_angle);
    assign op_c = trig_op(r_angle + ANGLE_W'(16384));

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SIN: begin
                mul_a = MA_W'(op_s.diff);
                mul_b = MB_W'(op_s.frac);
            end
            S_COS: begin
                mul_a = MA_W'(op_c.diff);
                mul_b = MB_W'(op_c.frac);
            end
            S_MUL: begin
                mul_a = MA_W'(r_step[0] ? r_h : r_w);
                mul_b = MB_W'(r_step[1] ? r_cos : r_sin);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_slots_used  = r_slots_used;
        n_index_total = r_index_total;
        n_idx         = r_idx;
        n_step        = r_step;
        n_corner      = r_corner;
        n_ovalid      = (load_end || load_corner) ? 1'b1 : (o_out.ready ? 1'b0 : r_ovalid);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.kind) begin
                        n_slots_used  = CNT_W'(1);
                        n_index_total = '0;
                        n_state       = S_END;
                    end else begin
                        // close a full batch before this quad
                        if (r_index_total >= IDX_W'(MAX_INDICES) ||
                            r_slots_used >= CNT_W'(MAX_SLOTS)) begin
                            n_slots_used  = CNT_W'(1);
                            n_index_total = IDX_W'(QUAD_INDICES);
                        end else begin
                            n_index_total = r_index_total + IDX_W'(QUAD_INDICES);
                        end
                        n_idx   = '0;
                        n_state = S_SEARCH;
                    end
                end
            end
            S_END: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SEARCH: begin
                if (search_miss) begin
                    n_slots_used = r_slots_used + CNT_W'(1);
                    n_state      = S_SIN;
                end else if (search_hit) begin
                    n_state = S_SIN;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_SIN: begin
                n_state = S_COS;
            end
            S_COS: begin
                n_step  = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd4) begin
                    n_corner = '0;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_corner = r_corner + 2'd1;
                    if (r_corner == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_slots_used  <= CNT_W'(1);
            r_index_total <= '0;
            r_idx         <= '0;
            r_step        <= '0;
            r_corner      <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_slots_used  <= n_slots_used;
            r_index_total <= n_index_total;
            r_idx         <= n_idx;
            r_step        <= n_step;
            r_corner      <= n_corner;
            r_ovalid      <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx    <= i_in.center_x;
            r_cy    <= i_in.center_y;
            r_z     <= i_in.depth_z;
            r_color <= i_in.fill_color;
            r_w     <= i_in.quad_width;
            r_h     <= i_in.quad_height;
            r_angle <= i_in.angle;
            r_tex   <= i_in.texture_id;
            r_fcnt  <= r_index_total;
            r_flush <= i_in.kind || (r_index_total >= IDX_W'(MAX_INDICES)) ||
                       (r_slots_used >= CNT_W'(MAX_SLOTS));
        end
        if (search_miss) begin
            r_slot                        <= r_slots_used[SLOT_W-1:0];
            r_table[r_slots_used[SLOT_W-1:0]] <= r_tex;
        end else if (search_hit) begin
            r_slot <= r_idx[SLOT_W-1:0];
        end
        if (r_state == S_COS) begin
            r_sin <= trig_val(op_s, mul_p);
        end
        if (r_state == S_MUL && r_step == 3'd0) begin
            r_cos <= trig_val(op_c, mul_p);
        end
        if (r_state == S_MUL && r_step != 3'd0) begin
            r_p[2'(r_step - 3'd1)] <= mul_p;
        end
        if (load_end) begin
            r_ox     <= '0;
            r_oy     <= '0;
            r_oz     <= '0;
            r_ocolor <= '0;
            r_ou     <= 1'b0;
            r_ov     <= 1'b0;
            r_oslot  <= '0;
            r_oflush <= 1'b1;
            r_ofcnt  <= r_fcnt;
            r_olast  <= 1'b1;
        end else if (load_corner) begin
            r_ox     <= cx_out;
            r_oy     <= cy_out;
            r_oz     <= r_z;
            r_ocolor <= r_color;
            // uv corners in order (0,0) (1,0) (1,1) (0,1)
            r_ou     <= r_corner[0] ^ r_corner[1];
            r_ov     <= r_corner[1];
            r_oslot  <= r_slot;
            r_oflush <= (r_corner == 2'd0) && r_flush;
            r_ofcnt  <= ((r_corner == 2'd0) && r_flush) ? r_fcnt : '0;
            r_olast  <= (r_corner == 2'd3);
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.vertex_x        = r_ox;
    assign o_out.vertex_y        = r_oy;
    assign o_out.vertex_z        = r_oz;
    assign o_out.vertex_color    = r_ocolor;
    assign o_out.tex_u           = r_ou;
    assign o_out.tex_v           = r_ov;
    assign o_out.slot_index      = r_oslot;
    assign o_out.flush_before    = r_oflush;
    assign o_out.flushed_indices = r_ofcnt;
    assign o_out.last            = r_olast;

    // slot count stays within the table
    a_slots_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slots_used >= CNT_W'(1)) && (r_slots_used <= CNT_W'(MAX_SLOTS)))
        else $error("slot count out of range");

    // the search index never passes the count of slots in use
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_idx <= r_slots_used))
        else $error("slot search past used slots");

    // a flush is only reported on the first corner or on an end item
    a_flush_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.flush_before) |-> (!o_out.tex_u && !o_out.tex_v))
        else $error("flush reported on a later corner");

    // index count stays below the limit plus one quad
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index_total < IDX_W'(MAX_INDICES + QUAD_INDICES))
        else $error("index count overflow");

endmodule

>>> tb/sprite_quad_batch_generator_unit_tb.sv
`timescale 1ns / 100ps

module sprite_quad_batch_generator_unit_tb;
    import sqbg_pkg::*;

    typedef struct {
        bit                        kind;
        logic signed [XY_W-1:0]    cx;
        logic signed [XY_W-1:0]    cy;
        logic signed [Z_W-1:0]     z;
        logic [COLOR_W-1:0]        color;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
        logic [ANGLE_W-1:0]        angle;
        logic [TEX_W-1:0]          tex;
    } sprite_t;

    typedef struct packed {
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [Z_W-1:0]     z;
        logic [COLOR_W-1:0]        color;
        logic                      u;
        logic                      v;
        logic [SLOT_W-1:0]         slot;
        logic                      flush;
        logic [IDX_W-1:0]          flushed;
        logic                      last;
    } corner_t;

    // batch state mirror and the corners still owed by the block
    class quad_scoreboard;
        logic [TEX_W-1:0] slot_names [MAX_SLOTS];
        int               used_slots;
        int               batch_indices;
        corner_t          owed [$];
        int               mismatches;

        function new();
            close_batch();
            mismatches = 0;
        endfunction

        function void close_batch();
            foreach (slot_names[i]) slot_names[i] = '0;
            used_slots    = 1;
            batch_indices = 0;
        endfunction

        function longint quarter_wave(int x);
            int tab [17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
                             12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};
            int idx;
            idx = x >> 10;
            if (idx >= 16) return 16384;
            return tab[idx] + (((tab[idx+1] - tab[idx]) * (x & 1023)) >> 10);
        endfunction

        function longint sine_q14(int a);
            int     r;
            longint mag;
            a   = a & 16'hFFFF;
            r   = a & 16'h3FFF;
            mag = a[14] ? quarter_wave(16384 - r) : quarter_wave(r);
            return a[15] ? -mag : mag;
        endfunction

        // halve and drop the q14 scale, rounding half up, then saturate onto the center
        function logic [XY_W-1:0] place(longint center, longint prod);
            longint p;
            p = center + ((prod + 16384) >>> 15);
            if (p < -8388608) p = -8388608;
            if (p > 8388607) p = 8388607;
            return p[XY_W-1:0];
        endfunction

        function void note_sprite(sprite_t s);
            corner_t e;
            int      sx [4] = '{-1, 1, 1, -1};
            int      sy [4] = '{-1, -1, 1, 1};
            bit      flush;
            int      old_count, slot;
            bit      hit;
            longint  c, sn, w, h;
            e = '0;
            if (s.kind) begin
                e.flush   = 1'b1;
                e.flushed = IDX_W'(batch_indices);
                e.last    = 1'b1;
                owed.push_back(e);
                close_batch();
                return;
            end
            flush     = 0;
            old_count = 0;
            if (batch_indices >= MAX_INDICES || used_slots >= MAX_SLOTS) begin
                flush     = 1;
                old_count = batch_indices;
                close_batch();
            end
            hit  = 0;
            slot = 0;
            for (int i = 0; i < used_slots && i < MAX_SLOTS; i++)
                if (!hit && slot_names[i] == s.tex) begin
                    hit  = 1;
                    slot = i;
                end
            if (!hit) begin
                slot             = used_slots & 31;
                slot_names[slot] = s.tex;
                used_slots       = (used_slots + 1) & 63;
            end
            w  = s.w;
            h  = s.h;
            c  = sine_q14(s.angle + 16384);
            sn = sine_q14(s.angle);
            for (int k = 0; k < 4; k++) begin
                e.x       = place(s.cx, sx[k] * w * c - sy[k] * h * sn);
                e.y       = place(s.cy, sx[k] * w * sn + sy[k] * h * c);
                e.z       = s.z;
                e.color   = s.color;
                e.u       = (k == 1 || k == 2);
                e.v       = (k >= 2);
                e.slot    = SLOT_W'(slot);
                e.flush   = (k == 0) ? flush : 1'b0;
                e.flushed = (k == 0) ? IDX_W'(old_count) : '0;
                e.last    = (k == 3);
                owed.push_back(e);
            end
            batch_indices = (batch_indices + QUAD_INDICES) & 13'h1FFF;
        endfunction

        function void check_corner(corner_t got);
            corner_t e;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex item: x=%0d y=%0d", got.x, got.y);
                return;
            end
            e = owed.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("vertex mismatch: exp x=%0d y=%0d z=%0d c=%h uv=%b%b s=%0d f=%b/%0d l=%b",
                             e.x, e.y, e.z, e.color, e.u, e.v, e.slot, e.flush,
                             e.flushed, e.last,
                             "\n                 got x=%0d y=%0d z=%0d c=%h uv=%b%b s=%0d f=%b/%0d l=%b",
                             got.x, got.y, got.z, got.color, got.u, got.v, got.slot,
                             got.flush, got.flushed, got.last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sqbg_in_if  in_if ();
    sqbg_out_if out_if ();

    sprite_quad_batch_generator_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    quad_scoreboard sb = new();

    bit  calm = 0;          // no idling on either side in the closing stretch
    bit  hold_sink = 0;     // asks the receiver for one long hold-off
    int  cycles = 0;
    localparam int CYCLE_LIMIT = 1_500_000;

    logic [TEX_W-1:0] tex_pool [6];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // global watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // vertex monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_corner('{out_if.vertex_x, out_if.vertex_y, out_if.vertex_z,
                              out_if.vertex_color, out_if.tex_u, out_if.tex_v,
                              out_if.slot_index, out_if.flush_before,
                              out_if.flushed_indices, out_if.last});
    end

    // receiver: random stall bursts, one long hold when asked
    initial begin
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                out_if.ready = 1'b0;
                repeat (300) @(negedge i_clk);
                hold_sink = 0;
                out_if.ready = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_if.ready = 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    // present one item from the falling edge until it is taken
    task automatic send_sprite(sprite_t s);
        in_if.valid       = 1'b1;
        in_if.kind        = s.kind;
        in_if.center_x    = s.cx;
        in_if.center_y    = s.cy;
        in_if.depth_z     = s.z;
        in_if.fill_color  = s.color;
        in_if.quad_width  = s.w;
        in_if.quad_height = s.h;
        in_if.angle       = s.angle;
        in_if.texture_id  = s.tex;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_sprite(s);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
        end
    endtask

    function automatic sprite_t make_quad(logic [TEX_W-1:0] tex, logic [ANGLE_W-1:0] ang,
                                          logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        sprite_t s;
        s.kind  = 0;
        s.cx    = XY_W'($urandom);
        s.cy    = XY_W'($urandom);
        s.z     = Z_W'($urandom);
        s.color = $urandom;
        s.w     = w;
        s.h     = h;
        s.angle = ang;
        s.tex   = tex;
        return s;
    endfunction

    function automatic sprite_t random_quad();
        sprite_t s;
        logic [TEX_W-1:0] tex;
        case ($urandom_range(0, 5))
            0:       tex = $urandom;
            1:       tex = '0;
            default: tex = tex_pool[$urandom_range(0, 5)];
        endcase
        if ($urandom_range(0, 15) == 0)
            s = make_quad(tex, ANGLE_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom));
        else
            s = make_quad(tex, ANGLE_W'($urandom), SIZE_W'($urandom_range(0, 8191)),
                          SIZE_W'($urandom_range(0, 8191)));
        // keep some corners near the saturation edges
        if ($urandom_range(0, 9) == 0) s.cx = {$urandom_range(0, 1) ? 2'b01 : 2'b10, 22'h3FFFF0};
        if ($urandom_range(0, 9) == 0) s.cy = {$urandom_range(0, 1) ? 2'b01 : 2'b10, 22'h3FFFF0};
        return s;
    endfunction

    function automatic sprite_t end_batch();
        sprite_t s;
        s      = make_quad($urandom, ANGLE_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom));
        s.kind = 1;
        return s;
    endfunction

    task automatic drain();
        while (sb.owed.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    initial begin
        sprite_t s;
        in_if.valid       = 1'b0;
        in_if.kind        = 1'b0;
        in_if.center_x    = '0;
        in_if.center_y    = '0;
        in_if.depth_z     = '0;
        in_if.fill_color  = '0;
        in_if.quad_width  = '0;
        in_if.quad_height = '0;
        in_if.angle       = '0;
        in_if.texture_id  = '0;
        foreach (tex_pool[i]) tex_pool[i] = $urandom;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty batch end, extremes, quadrant angles, untextured, hits
        send_sprite(end_batch());
        s = '{0, '0, '0, '0, '0, '0, '0, '0, '0};
        send_sprite(s);
        s = '{0, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              16'hFFFF, 32'hFFFFFFFF};
        send_sprite(s);
        s = '{0, 24'h800000, 24'h800000, 16'h8000, 32'h0, 24'hFFFFFF, 24'hFFFFFF,
              16'h0, 32'h1};
        send_sprite(s);
        foreach (tex_pool[i])
            send_sprite(make_quad(tex_pool[i], ANGLE_W'(16'h4000 * i + 16'h2000 * (i / 4)),
                                  24'h1000, 24'h0800));
        send_sprite(make_quad(32'hFFFFFFFF, 16'h0001, 24'h0100, 24'h0300));
        send_sprite(make_quad(tex_pool[2], 16'h8000, 24'h0, 24'h0100));
        send_sprite(make_quad('0, 16'hC000, 24'h0200, 24'h0));
        send_sprite(make_quad('0, 16'h3FFF, 24'h0400, 24'h0400));
        send_sprite(end_batch());
        send_sprite(end_batch());

        // fill every texture slot so the next quad closes the batch
        for (int i = 0; i < 33; i++)
            send_sprite(make_quad(32'h1000_0000 + i, ANGLE_W'($urandom),
                                  SIZE_W'($urandom_range(0, 4095)),
                                  SIZE_W'($urandom_range(0, 4095))));

        // receiver holds off while items keep coming
        hold_sink = 1;
        repeat (12) send_sprite(random_quad());

        // sender waits for the block to go empty
        in_if.valid = 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);

        send_sprite(end_batch());

        for (int i = 0; i < 108; i++) begin
            if (i == 88) calm = 1;
            send_sprite(($urandom_range(0, 19) == 0) ? end_batch() : random_quad());
        end
        in_if.valid = 1'b0;

        drain();
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
